### src/arps_pkg.sv
// shared types, codes and helpers of the amplifier relay power sequencer
package arps_pkg;

	localparam int TICK_W      = 16;
	localparam int SENSE_DBN_W = TICK_W + 1;
	localparam int CFG_INDEX_W = 2;

	localparam logic [TICK_W-1:0] SHORT_TICKS_RST = 16'd50;
	localparam logic [TICK_W-1:0] LONG_TICKS_RST  = 16'd1000;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_SHORT_TICKS = 2'd0,
		REG_LONG_TICKS  = 2'd1
	} cfg_reg_t;

	typedef struct packed {
		logic switch_level;
		logic sense_level;
	} in_item_t;

	typedef struct packed {
		logic drive_a;
		logic drive_b;
		logic amp_release;
		logic led;
	} out_item_t;

	typedef struct packed {
		logic set_on;
		logic set_off;
		logic set_fault;
	} dbn_event_t;

	typedef struct packed {
		logic coil_a;
		logic coil_b;
		logic amp_rel;
	} coil_drive_t;

	typedef enum logic [13:0] {
		ST_CLASSIFY    = 14'h0001,
		ST_START_WAIT  = 14'h0002,
		ST_START_PULSE = 14'h0004,
		ST_FIX_WAIT    = 14'h0008,
		ST_FIX_PULSE   = 14'h0010,
		ST_FIX_LONG    = 14'h0020,
		ST_SR_WAIT     = 14'h0040,
		ST_SR_P1       = 14'h0080,
		ST_SR_P2       = 14'h0100,
		ST_SR_P3       = 14'h0200,
		ST_SR_LONG     = 14'h0400,
		ST_WARN_HOLD   = 14'h0800,
		ST_WARN_GAP    = 14'h1000,
		ST_POST_LONG   = 14'h2000
	} seq_state_t;

	function automatic logic [TICK_W-1:0] eff_ticks(input logic [TICK_W-1:0] v);
		eff_ticks = (v == '0) ? {{(TICK_W-1){1'b0}}, 1'b1} : v;
	endfunction

endpackage

### src/amp_relay_power_sequencer_unit.sv
// top level of the amplifier relay power sequencer
// One beat in is one millisecond tick carrying the switch and relay-sense levels; one result
// beat comes out for every tick. A tick lands in an input register and, once the result side
// can take it, is worked off through the debouncers and the sequencer into the result
// register; one tick can be accepted in every cycle while the result side keeps up. The delay
// registers are written at any time through the configuration port, which is always ready; a
// delay already running keeps its length.
module amp_relay_power_sequencer_unit import arps_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   item_valid,
	output logic                   item_stall,
	input  in_item_t               item,
	output logic                   result_valid,
	input  logic                   result_stall,
	output out_item_t              result,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [TICK_W-1:0]      cfg_data
);

	logic              in_valid_s1;
	in_item_t          in_s1;
	logic              advance;
	logic              accept;
	logic [TICK_W-1:0] short_ticks_q;
	logic [TICK_W-1:0] long_ticks_q;
	dbn_event_t        ev;
	logic              led_n;
	coil_drive_t       drv_n;
	logic              result_valid_q;
	out_item_t         result_q;

	assign cfg_ready    = 1'b1;
	assign advance      = in_valid_s1 && (!result_valid_q || !result_stall);
	assign item_stall   = in_valid_s1 && !advance;
	assign accept       = item_valid && !item_stall;
	assign result_valid = result_valid_q;
	assign result       = result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			short_ticks_q <= SHORT_TICKS_RST;
			long_ticks_q  <= LONG_TICKS_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_SHORT_TICKS: short_ticks_q <= cfg_data;
				REG_LONG_TICKS:  long_ticks_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (accept) begin
			in_valid_s1 <= 1'b1;
		end else if (advance) begin
			in_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			in_s1 <= item;
	end

	arps_debounce u_debounce (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (advance),
		.sw          (in_s1.switch_level),
		.se          (in_s1.sense_level),
		.short_ticks (short_ticks_q),
		.ev          (ev),
		.led_n       (led_n)
	);

	arps_seq u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (advance),
		.sw          (in_s1.switch_level),
		.se          (in_s1.sense_level),
		.short_ticks (short_ticks_q),
		.long_ticks  (long_ticks_q),
		.ev          (ev),
		.drv_n       (drv_n)
	);

	// result beat register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q.drive_a     <= drv_n.coil_a;
			result_q.drive_b     <= drv_n.coil_b;
			result_q.amp_release <= drv_n.amp_rel;
			result_q.led         <= led_n;
		end
	end

endmodule

### src/arps_debounce.sv
// switch and sense debouncers with the indicator toggle
module arps_debounce import arps_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic              sw,
	input  logic              se,
	input  logic [TICK_W-1:0] short_ticks,
	output dbn_event_t        ev,
	output logic              led_n
);

	logic [TICK_W-1:0]      sw_cnt_q, sw_cnt_n;
	logic                   sw_pend_q, sw_pend_n;
	logic                   sw_prev_q;
	logic [SENSE_DBN_W-1:0] se_cnt_q, se_cnt_n;
	logic                   se_pend_q, se_pend_n;
	logic                   se_prev_q;
	logic                   led_q;
	logic [TICK_W-1:0]      short_eff;
	logic [SENSE_DBN_W-1:0] sense_len;

	assign short_eff = eff_ticks(short_ticks);
	assign sense_len = {short_eff, 1'b0};

	always_comb begin
		ev        = '0;
		led_n     = led_q;
		sw_cnt_n  = sw_cnt_q;
		sw_pend_n = sw_pend_q;
		se_cnt_n  = se_cnt_q;
		se_pend_n = se_pend_q;

		if (sw_cnt_q != '0) begin
			sw_cnt_n = sw_cnt_q - 1'b1;
			if (sw_cnt_n == '0) begin
				ev.set_on  = sw;
				ev.set_off = !sw;
				led_n      = !led_n;
				if (sw_pend_q) begin
					sw_pend_n = 1'b0;
					sw_cnt_n  = short_eff;
				end
			end
		end
		if (sw != sw_prev_q) begin
			if (sw_cnt_n != '0)
				sw_pend_n = 1'b1;
			else
				sw_cnt_n = short_eff;
		end

		if (se_cnt_q != '0) begin
			se_cnt_n = se_cnt_q - 1'b1;
			if (se_cnt_n == '0) begin
				if (!se && sw) begin
					ev.set_fault = 1'b1;
					led_n        = !led_n;
				end
				if (se_pend_q) begin
					se_pend_n = 1'b0;
					se_cnt_n  = sense_len;
				end
			end
		end
		if (se_prev_q && !se) begin
			if (se_cnt_n != '0)
				se_pend_n = 1'b1;
			else
				se_cnt_n = sense_len;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sw_cnt_q  <= '0;
			sw_pend_q <= 1'b0;
			sw_prev_q <= 1'b1;
			se_cnt_q  <= '0;
			se_pend_q <= 1'b0;
			se_prev_q <= 1'b1;
			led_q     <= 1'b1;
		end else if (step) begin
			sw_cnt_q  <= sw_cnt_n;
			sw_pend_q <= sw_pend_n;
			sw_prev_q <= sw;
			se_cnt_q  <= se_cnt_n;
			se_pend_q <= se_pend_n;
			se_prev_q <= se;
			led_q     <= led_n;
		end
	end

endmodule

### src/arps_seq.sv
// relay and amplifier reset sequencer with its flags and delay timer
module arps_seq import arps_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic              sw,
	input  logic              se,
	input  logic [TICK_W-1:0] short_ticks,
	input  logic [TICK_W-1:0] long_ticks,
	input  dbn_event_t        ev,
	output coil_drive_t       drv_n
);

	seq_state_t        state_q, state_n;
	logic [TICK_W-1:0] timer_q, timer_n;
	logic [1:0]        rep_q, rep_n;
	logic              on_q, on_n;
	logic              off_q, off_n;
	logic              fault_q, fault_n;
	coil_drive_t       drv_q;
	logic [TICK_W-1:0] short_eff;
	logic [TICK_W-1:0] long_eff;
	logic              do_classify;
	logic              do_finish;
	logic              do_warn;

	assign short_eff = eff_ticks(short_ticks);
	assign long_eff  = eff_ticks(long_ticks);

	always_comb begin
		state_n     = state_q;
		timer_n     = timer_q;
		rep_n       = rep_q;
		on_n        = on_q | ev.set_on;
		off_n       = off_q | ev.set_off;
		fault_n     = fault_q | ev.set_fault;
		drv_n       = drv_q;
		do_classify = 1'b0;
		do_finish   = 1'b0;
		do_warn     = 1'b0;

		if (state_q == ST_CLASSIFY) begin
			do_classify = 1'b1;
		end else if (timer_q > 16'd1) begin
			timer_n = timer_q - 16'd1;
		end else begin
			unique case (state_q)
				ST_START_WAIT, ST_FIX_WAIT: begin
					drv_n.coil_a = 1'b1;
					drv_n.coil_b = 1'b0;
					timer_n      = short_eff;
					rep_n        = 2'd2;
					state_n      = (state_q == ST_START_WAIT) ? ST_START_PULSE : ST_FIX_PULSE;
				end
				ST_START_PULSE, ST_FIX_PULSE: begin
					if (rep_q != 2'd0) begin
						rep_n   = rep_q - 2'd1;
						timer_n = short_eff;
					end else begin
						drv_n.coil_a = 1'b0;
						drv_n.coil_b = 1'b0;
						off_n        = 1'b0;
						if (state_q == ST_START_PULSE) begin
							state_n = ST_CLASSIFY;
						end else begin
							timer_n = long_eff;
							state_n = ST_FIX_LONG;
						end
					end
				end
				ST_FIX_LONG, ST_POST_LONG: begin
					state_n = ST_CLASSIFY;
				end
				ST_SR_WAIT: begin
					drv_n.coil_a = !sw;
					drv_n.coil_b = sw;
					timer_n      = short_eff;
					state_n      = ST_SR_P1;
				end
				ST_SR_P1: begin
					timer_n = short_eff;
					state_n = ST_SR_P2;
				end
				ST_SR_P2: begin
					timer_n = short_eff;
					state_n = ST_SR_P3;
				end
				ST_SR_P3: begin
					drv_n.coil_a = 1'b0;
					drv_n.coil_b = 1'b0;
					if (on_n) begin
						timer_n = long_eff;
						state_n = ST_SR_LONG;
					end else begin
						do_finish = 1'b1;
					end
				end
				ST_SR_LONG: begin
					drv_n.amp_rel = 1'b1;
					on_n          = 1'b0;
					do_finish     = 1'b1;
				end
				ST_WARN_HOLD: begin
					if (rep_q != 2'd0) begin
						rep_n   = rep_q - 2'd1;
						timer_n = long_eff;
					end else begin
						drv_n.amp_rel = 1'b1;
						timer_n       = short_eff;
						rep_n         = 2'd1;
						state_n       = ST_WARN_GAP;
					end
				end
				ST_WARN_GAP: begin
					if (rep_q != 2'd0) begin
						rep_n   = rep_q - 2'd1;
						timer_n = short_eff;
					end else begin
						do_warn = 1'b1;
					end
				end
				default: begin
					do_classify = 1'b1;
				end
			endcase
		end

		// finish of a relay switch
		if (do_finish) begin
			off_n = 1'b0;
			if (rep_q == 2'd0) begin
				do_warn = 1'b1;
			end else begin
				if (rep_q == 2'd2)
					fault_n = 1'b0;
				state_n = ST_CLASSIFY;
			end
		end

		// fault loop entry or, without a standing fault, the long post delay
		if (do_warn) begin
			timer_n = long_eff;
			if (sw && fault_n && !se) begin
				drv_n.amp_rel = 1'b0;
				rep_n         = 2'd2;
				state_n       = ST_WARN_HOLD;
			end else begin
				drv_n.amp_rel = 1'b1;
				fault_n       = 1'b0;
				state_n       = ST_POST_LONG;
			end
		end

		if (do_classify) begin
			state_n = ST_CLASSIFY;
			if (!sw && se && !off_n) begin
				timer_n = short_eff;
				state_n = ST_FIX_WAIT;
			end else if (sw != se) begin
				if (sw)
					rep_n = on_n ? 2'd1 : 2'd0;
				else
					rep_n = 2'd2;
				if (on_n)
					drv_n.amp_rel = 1'b0;
				timer_n = short_eff;
				state_n = ST_SR_WAIT;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_START_WAIT;
			timer_q <= SHORT_TICKS_RST;
			rep_q   <= 2'd0;
			on_q    <= 1'b0;
			off_q   <= 1'b0;
			fault_q <= 1'b0;
			drv_q   <= '{coil_a: 1'b0, coil_b: 1'b0, amp_rel: 1'b1};
		end else if (step) begin
			state_q <= state_n;
			timer_q <= timer_n;
			rep_q   <= rep_n;
			on_q    <= on_n;
			off_q   <= off_n;
			fault_q <= fault_n;
			drv_q   <= drv_n;
		end
	end

endmodule

### test/tb.sv
// testbench of the amplifier relay power sequencer: ticks in, predicted coil and led beats out
module tb;
	import arps_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_CYCLES = 150;
	localparam int MAX_PRINTS  = 50;

	localparam logic [CFG_INDEX_W-1:0] REG_SPARE_2 = 2'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_SPARE_3 = 2'd3;

	localparam logic [1:0] CASE_FAULT_LOOP  = 2'd0;
	localparam logic [1:0] CASE_PLAIN       = 2'd1;
	localparam logic [1:0] CASE_CLEAR_FAULT = 2'd2;

	// {switch, sense} per tick, first tick in the top bits
	localparam logic [11:0] SCRIPT_BOOT = {2'b11, 2'b01, 2'b00, 2'b10, 2'b11, 2'b01};
	localparam logic [35:0] SCRIPT_EDGES = {
		2'b11, 2'b11, 2'b01, 2'b01, 2'b01, 2'b01, 2'b11, 2'b01, 2'b11,
		2'b11, 2'b10, 2'b10, 2'b10, 2'b10, 2'b10, 2'b00, 2'b01, 2'b10
	};

	class relay_scoreboard;
		logic [TICK_W-1:0]      short_q, long_q;
		seq_state_t             step;
		logic [TICK_W-1:0]      timer;
		logic [1:0]             rep;
		logic                   on_f, off_f, fault_f;
		logic                   sw_prev, se_prev;
		logic [TICK_W-1:0]      sw_dbn;
		logic                   sw_pend;
		logic [SENSE_DBN_W-1:0] se_dbn;
		logic                   se_pend;
		logic                   coil_a, coil_b, rel, led;
		out_item_t              exp_q[$];
		int                     errors;
		int                     beats;

		function new();
			errors = 0;
			beats = 0;
			short_q = SHORT_TICKS_RST;
			long_q = LONG_TICKS_RST;
			step = ST_START_WAIT;
			timer = SHORT_TICKS_RST;
			rep = '0;
			on_f = 1'b0;
			off_f = 1'b0;
			fault_f = 1'b0;
			sw_prev = 1'b1;
			se_prev = 1'b1;
			sw_dbn = '0;
			sw_pend = 1'b0;
			se_dbn = '0;
			se_pend = 1'b0;
			coil_a = 1'b0;
			coil_b = 1'b0;
			rel = 1'b1;
			led = 1'b1;
		endfunction

		function logic [TICK_W-1:0] at_least_one(input logic [TICK_W-1:0] v);
			return (v == '0) ? 16'd1 : v;
		endfunction

		function int run_span();
			int s;
			s = 4 * int'(at_least_one(short_q)) + int'(at_least_one(long_q)) + 4;
			return (s > 40) ? 40 : s;
		endfunction

		function int pending();
			return exp_q.size();
		endfunction

		function void set_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [TICK_W-1:0] val);
			if (idx == REG_SHORT_TICKS)
				short_q = val;
			else if (idx == REG_LONG_TICKS)
				long_q = val;
		endfunction

		function void enter_warn(input logic sw, input logic se);
			if (sw && fault_f && !se) begin
				rel = 1'b0;
				timer = at_least_one(long_q);
				rep = 2'd2;
				step = ST_WARN_HOLD;
			end else begin
				rel = 1'b1;
				fault_f = 1'b0;
				timer = at_least_one(long_q);
				step = ST_POST_LONG;
			end
		endfunction

		function void finish_switch(input logic sw, input logic se);
			off_f = 1'b0;
			if (rep == CASE_FAULT_LOOP) begin
				enter_warn(sw, se);
			end else begin
				if (rep == CASE_CLEAR_FAULT)
					fault_f = 1'b0;
				step = ST_CLASSIFY;
			end
		endfunction

		function void expire(input logic sw, input logic se);
			case (step)
				ST_START_WAIT, ST_FIX_WAIT: begin
					coil_a = 1'b1;
					coil_b = 1'b0;
					timer = at_least_one(short_q);
					rep = 2'd2;
					if (step == ST_START_WAIT)
						step = ST_START_PULSE;
					else
						step = ST_FIX_PULSE;
				end
				ST_START_PULSE, ST_FIX_PULSE: begin
					if (rep != 0) begin
						rep = rep - 2'd1;
						timer = at_least_one(short_q);
					end else begin
						coil_a = 1'b0;
						coil_b = 1'b0;
						off_f = 1'b0;
						if (step == ST_START_PULSE) begin
							step = ST_CLASSIFY;
						end else begin
							timer = at_least_one(long_q);
							step = ST_FIX_LONG;
						end
					end
				end
				ST_SR_WAIT: begin
					coil_a = ~sw;
					coil_b = sw;
					timer = at_least_one(short_q);
					step = ST_SR_P1;
				end
				ST_SR_P1: begin
					timer = at_least_one(short_q);
					step = ST_SR_P2;
				end
				ST_SR_P2: begin
					timer = at_least_one(short_q);
					step = ST_SR_P3;
				end
				ST_SR_P3: begin
					coil_a = 1'b0;
					coil_b = 1'b0;
					if (on_f) begin
						timer = at_least_one(long_q);
						step = ST_SR_LONG;
					end else begin
						finish_switch(sw, se);
					end
				end
				ST_SR_LONG: begin
					rel = 1'b1;
					on_f = 1'b0;
					finish_switch(sw, se);
				end
				ST_WARN_HOLD: begin
					if (rep != 0) begin
						rep = rep - 2'd1;
						timer = at_least_one(long_q);
					end else begin
						rel = 1'b1;
						timer = at_least_one(short_q);
						rep = 2'd1;
						step = ST_WARN_GAP;
					end
				end
				ST_WARN_GAP: begin
					if (rep != 0) begin
						rep = rep - 2'd1;
						timer = at_least_one(short_q);
					end else begin
						enter_warn(sw, se);
					end
				end
				default: step = ST_CLASSIFY;
			endcase
		endfunction

		function void classify(input logic sw, input logic se);
			if (!sw && se && !off_f) begin
				timer = at_least_one(short_q);
				step = ST_FIX_WAIT;
			end else if (sw != se) begin
				if (sw)
					rep = on_f ? CASE_PLAIN : CASE_FAULT_LOOP;
				else
					rep = CASE_CLEAR_FAULT;
				if (on_f)
					rel = 1'b0;
				timer = at_least_one(short_q);
				step = ST_SR_WAIT;
			end
		endfunction

		function void note_tick(input in_item_t t);
			logic sw, se;
			sw = t.switch_level;
			se = t.sense_level;

			if (sw_dbn != '0) begin
				sw_dbn = sw_dbn - 1'b1;
				if (sw_dbn == '0) begin
					if (sw)
						on_f = 1'b1;
					else
						off_f = 1'b1;
					led = ~led;
					if (sw_pend) begin
						sw_pend = 1'b0;
						sw_dbn = at_least_one(short_q);
					end
				end
			end
			if (sw != sw_prev) begin
				if (sw_dbn != '0)
					sw_pend = 1'b1;
				else
					sw_dbn = at_least_one(short_q);
			end
			sw_prev = sw;

			if (se_dbn != '0) begin
				se_dbn = se_dbn - 1'b1;
				if (se_dbn == '0) begin
					if (!se && sw) begin
						fault_f = 1'b1;
						led = ~led;
					end
					if (se_pend) begin
						se_pend = 1'b0;
						se_dbn = {at_least_one(short_q), 1'b0};
					end
				end
			end
			if (se_prev && !se) begin
				if (se_dbn != '0)
					se_pend = 1'b1;
				else
					se_dbn = {at_least_one(short_q), 1'b0};
			end
			se_prev = se;

			if (step == ST_CLASSIFY)
				classify(sw, se);
			else if (timer > 16'd1)
				timer = timer - 1'b1;
			else if (step == ST_FIX_LONG || step == ST_POST_LONG)
				step = ST_CLASSIFY;
			else
				expire(sw, se);

			exp_q.push_back('{drive_a: coil_a, drive_b: coil_b, amp_release: rel, led: led});
		endfunction

		task report(input string what);
			errors++;
			if (errors <= MAX_PRINTS)
				$display("mismatch: %s", what);
		endtask

		task check_beat(input out_item_t got);
			out_item_t want;
			beats++;
			if (exp_q.size() == 0) begin
				report($sformatf("result beat %0d arrived with no tick pending", beats));
			end else begin
				want = exp_q.pop_front();
				if (got.drive_a !== want.drive_a || got.drive_b !== want.drive_b ||
				    got.amp_release !== want.amp_release || got.led !== want.led)
					report($sformatf("beat %0d a/b/release/led got %b%b%b%b want %b%b%b%b",
						beats, got.drive_a, got.drive_b, got.amp_release, got.led,
						want.drive_a, want.drive_b, want.amp_release, want.led));
			end
		endtask
	endclass

	logic                   clk;
	logic                   arst_n = 1'b0;
	logic                   item_valid = 1'b0;
	logic                   item_stall;
	in_item_t               item = '0;
	logic                   result_valid;
	logic                   result_stall = 1'b0;
	out_item_t              result;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [TICK_W-1:0]      cfg_data = '0;

	relay_scoreboard sb;
	logic            calm = 1'b0;
	logic            hold_req = 1'b0;
	int              hold_left = 0;
	int unsigned     cycles_run = 0;

	amp_relay_power_sequencer_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles_run++;
		if (cycles_run > CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && item_valid && !item_stall)
			sb.note_tick(item);
		if (arst_n && result_valid && !result_stall)
			sb.check_beat(result);
	end

	// result side back-pressure, with a counted long hold-off on request
	initial begin
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_left = HOLD_CYCLES;
				hold_req = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_stall <= 1'b1;
			end else if (calm) begin
				result_stall <= 1'b0;
			end else begin
				result_stall <= ($urandom_range(99) < 34);
			end
		end
	end

	task automatic send_tick(input in_item_t t);
		int gap;
		gap = 0;
		if (!calm)
			while ($urandom_range(99) < 34)
				gap++;
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1'b1;
		item <= t;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
	endtask

	task automatic end_burst();
		item_valid <= 1'b0;
		do
			@(posedge clk);
		while (sb.pending() != 0);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [TICK_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		sb.set_reg(idx, val);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic run_script(input logic [63:0] script, input int n);
		int i;
		for (i = 0; i < n; i++)
			send_tick(in_item_t'(script[2*(n-1-i) +: 2]));
	endtask

	// level runs of up to one sequencer walk, at most 40 ticks, mixed with single-tick noise
	task automatic random_ticks(input int count, input int hold_at, input int pause_at);
		int   sent, len, k;
		logic sw, se;
		sent = 0;
		while (sent < count) begin
			sw = 1'($urandom_range(1));
			se = 1'($urandom_range(1));
			if ($urandom_range(99) < 20)
				len = 1;
			else
				len = $urandom_range(sb.run_span(), 1);
			for (k = 0; k < len && sent < count; k++) begin
				if (sent == hold_at)
					hold_req = 1'b1;
				if (sent == pause_at)
					end_burst();
				send_tick({sw, se});
				sent++;
			end
		end
	endtask

	initial begin
		sb = new();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		run_script(64'(SCRIPT_BOOT), 6);
		end_burst();
		write_reg(REG_SHORT_TICKS, 16'd2);
		write_reg(REG_LONG_TICKS, 16'd3);
		write_reg(REG_SPARE_2, 16'($urandom));
		write_reg(REG_SPARE_3, 16'($urandom));
		run_script(64'(SCRIPT_EDGES), 18);

		end_burst();
		write_reg(REG_SHORT_TICKS, 16'd1);
		write_reg(REG_LONG_TICKS, 16'd1);
		random_ticks(60, 20, -1);

		end_burst();
		write_reg(REG_SHORT_TICKS, 16'd0);
		write_reg(REG_LONG_TICKS, 16'd0);
		calm = 1'b1;
		random_ticks(60, -1, -1);
		calm = 1'b0;

		end_burst();
		write_reg(REG_SHORT_TICKS, 16'd3);
		write_reg(REG_LONG_TICKS, 16'd6);
		random_ticks(70, -1, 35);

		end_burst();
		write_reg(REG_SHORT_TICKS, 16'($urandom_range(5, 1)));
		write_reg(REG_LONG_TICKS, 16'($urandom_range(12, 1)));
		write_reg(REG_SPARE_2, 16'hffff);
		random_ticks(80, 50, -1);

		end_burst();
		write_reg(REG_SHORT_TICKS, 16'd2);
		write_reg(REG_LONG_TICKS, 16'd16);
		random_ticks(70, -1, -1);

		end_burst();
		write_reg(REG_SHORT_TICKS, 16'hffff);
		write_reg(REG_LONG_TICKS, 16'hffff);
		random_ticks(30, -1, -1);

		end_burst();
		repeat (8) @(posedge clk);
		if (sb.pending() != 0)
			sb.report($sformatf("%0d expected beats never arrived", sb.pending()));
		if (sb.errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

### filelist.f
src/arps_pkg.sv
src/arps_debounce.sv
src/arps_seq.sv
src/amp_relay_power_sequencer_unit.sv
test/tb.sv
